FILE: src/sphc_pkg.sv
package sphc_pkg;

  localparam int unsigned HashW = 31;
  localparam int unsigned IdxW  = 10;

  // Opcodes
  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_APPEND  = 3'd1;
  localparam logic [2:0] OP_HASH    = 3'd2;
  localparam logic [2:0] OP_CMP     = 3'd3;
  localparam logic [2:0] OP_CMP_GIV = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Register indexes
  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_MOD  = 1'b1;

  localparam logic [HashW-1:0] BASE_RST = 31'd53;
  localparam logic [HashW-1:0] MOD_RST  = 31'd1000000007;
  localparam logic [7:0]       LETTER_OFS = 8'd96;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [7:0]       symbol;
    logic [IdxW-1:0]  start_a;
    logic [IdxW-1:0]  end_a;
    logic [IdxW-1:0]  start_b;
    logic [IdxW-1:0]  end_b;
    logic [HashW-1:0] given_hash;
  } cmd_t;

  typedef struct packed {
    logic [HashW-1:0] hash_value;
    logic             ranges_equal;
    logic [1:0]       status;
  } res_t;

endpackage

FILE: src/substring_poly_hash_compare_top.sv
// Polynomial prefix hash of a byte string held in two on-chip tables (prefix
// sums and base powers, MAX_LENGTH+1 entries each). Issue a command with
// start_i while busy_o is low; exactly one result appears later on res_o for
// a single cycle with res_valid_o, and it must be taken then, since the block
// cannot hold it. All modular products run through one shift-add modular
// multiplier, and one item runs at a time. Clear, errors, unused opcodes and
// compares of unequal length are answered from idle, their result strobe
// registered at the accepting edge; a range hash, an append and a compare go
// through table lookups and the multiplier (a given-hash compare reduces the
// given hash in place of hashing range A, and an offset between the two starts
// adds one alignment product). busy_o drops in the cycle of the strobe.
module substring_poly_hash_compare_top
  import sphc_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  cmd_t             cmd_i,
  output logic             res_valid_o,
  output res_t             res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [HashW-1:0] cfg_data_i
);

  localparam int unsigned LW = $clog2(MAX_LENGTH + 1);
  localparam int unsigned CW = (LW > IdxW) ? LW : IdxW;
  localparam int unsigned Depth = MAX_LENGTH + 1;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_AP_RD  = 14'b00000000000010,
    S_AP_PW  = 14'b00000000000100,
    S_AP_NP  = 14'b00000000001000,
    S_AP_V   = 14'b00000000010000,
    S_AP_T   = 14'b00000000100000,
    S_AP_P   = 14'b00000001000000,
    S_RH_HI  = 14'b00000010000000,
    S_RH_HIW = 14'b00000100000000,
    S_RH_LO  = 14'b00001000000000,
    S_RH_LOW = 14'b00010000000000,
    S_GH_W   = 14'b00100000000000,
    S_AL_RD  = 14'b01000000000000,
    S_AL_W   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [HashW-1:0] base_q, mod_q, m;
  assign cfg_ready_o = 1'b1;
  assign m = (mod_q < 31'd3) ? 31'd3 : mod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RST;
      mod_q  <= MOD_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_BASE) base_q <= cfg_data_i;
      else                         mod_q  <= cfg_data_i;
    end
  end

  // Tables
  logic [HashW-1:0] pre_mem [Depth];
  logic [HashW-1:0] pow_mem [Depth];
  logic [HashW-1:0] rd_pre_q, rd_pow_q;
  logic [LW-1:0]    rd_addr;
  logic             rd_zero_q, wr_en;
  logic [LW-1:0]    wr_addr;
  logic [HashW-1:0] wr_pre, wr_pow, pre_rd, pow_rd;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pre_mem[wr_addr] <= wr_pre;
      pow_mem[wr_addr] <= wr_pow;
    end
    rd_pre_q <= pre_mem[rd_addr];
    rd_pow_q <= pow_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_zero_q <= 1'b1;
    else         rd_zero_q <= (rd_addr == '0);
  end

  // Entry zero is fixed: prefix 0, power 1
  assign pre_rd = rd_zero_q ? '0 : rd_pre_q;
  assign pow_rd = rd_zero_q ? 31'd1 : rd_pow_q;

  // Shift-add modular multiplier: acc = a * b mod m, needs a < m
  logic             mm_go, mm_run_q;
  logic [HashW-1:0] mm_a, mm_b, mm_a_q, mm_b_q, mm_acc_q;
  logic [4:0]       mm_cnt_q;
  logic [HashW:0]   mm_dbl, mm_dbl_r, mm_sum, mm_sum_r;

  always_comb begin
    mm_dbl   = {mm_acc_q, 1'b0};
    mm_dbl_r = (mm_dbl >= {1'b0, m}) ? mm_dbl - {1'b0, m} : mm_dbl;
    mm_sum   = mm_b_q[HashW-1] ? mm_dbl_r + {1'b0, mm_a_q} : mm_dbl_r;
    mm_sum_r = (mm_sum >= {1'b0, m}) ? mm_sum - {1'b0, m} : mm_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_run_q <= 1'b0;
      mm_cnt_q <= '0;
    end else if (mm_go) begin
      mm_run_q <= 1'b1;
      mm_cnt_q <= 5'(HashW - 1);
    end else if (mm_run_q) begin
      mm_cnt_q <= mm_cnt_q - 5'd1;
      if (mm_cnt_q == '0) mm_run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mm_go) begin
      mm_acc_q <= '0;
      mm_a_q   <= mm_a;
      mm_b_q   <= mm_b;
    end else if (mm_run_q) begin
      mm_acc_q <= mm_sum_r[HashW-1:0];
      mm_b_q   <= {mm_b_q[HashW-2:0], 1'b0};
    end
  end

  // Command and working registers
  cmd_t             cmd_q;
  logic [LW-1:0]    len_q, len_d;
  logic             selb_q, selb_d;
  logic [HashW-1:0] pw_q, np_q, t_q, preraw_q, hi_q, ha_q, hb_q;
  logic             res_valid_q, res_valid_d;
  res_t             res_q, res_d;

  logic [CW-1:0]    sa, ea, sb, eb, lenx, pos_gap;
  logic             a_ok, b_ok, same_len, a_first, full;
  logic [7:0]       symdiff;
  logic             symneg;
  logic [HashW-1:0] vval, rh, psum;
  logic [HashW:0]   psum_w;

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    cmd_t c;
    c        = (state_q == S_IDLE) ? cmd_i : cmd_q;
    sa       = CW'(c.start_a);
    ea       = CW'(c.end_a);
    sb       = CW'(c.start_b);
    eb       = CW'(c.end_b);
    lenx     = CW'(len_q);
    a_ok     = (sa <= ea) && (ea < lenx);
    b_ok     = (sb <= eb) && (eb < lenx);
    same_len = (ea - sa) == (eb - sb);
    a_first  = sa < sb;
    pos_gap  = a_first ? sb - sa : sa - sb;
    full     = (len_q == LW'(MAX_LENGTH));
    symneg   = cmd_q.symbol < LETTER_OFS;
    symdiff  = symneg ? LETTER_OFS - cmd_q.symbol : cmd_q.symbol - LETTER_OFS;
    vval     = (symneg && (mm_acc_q != '0)) ? m - mm_acc_q : mm_acc_q;
    rh       = (hi_q >= mm_acc_q) ? hi_q - mm_acc_q : hi_q + (m - mm_acc_q);
    psum_w   = {1'b0, mm_acc_q} + {1'b0, t_q};
    psum     = (psum_w >= {1'b0, m}) ? psum_w[HashW-1:0] - m : psum_w[HashW-1:0];
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    selb_d      = selb_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = LW'(len_q + LW'(1));
    wr_pre      = psum;
    wr_pow      = np_q;
    mm_go       = 1'b0;
    mm_a        = 31'd1;
    mm_b        = pre_rd;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_d  = '0;
          selb_d = 1'b0;
          unique case (cmd_i.opcode) inside
            OP_CLEAR: begin
              len_d       = '0;
              res_valid_d = 1'b1;
            end
            OP_APPEND: begin
              if (full) begin
                res_d.status = ST_FULL;
                res_valid_d  = 1'b1;
              end else begin
                rd_addr = len_q;
                state_d = S_AP_RD;
              end
            end
            OP_HASH: begin
              if (!a_ok) begin
                res_d.status = ST_RANGE;
                res_valid_d  = 1'b1;
              end else begin
                rd_addr = LW'(ea + CW'(1));
                state_d = S_RH_HI;
              end
            end
            OP_CMP, OP_CMP_GIV: begin
              if (!a_ok || !b_ok) begin
                res_d.status = ST_RANGE;
                res_valid_d  = 1'b1;
              end else if (!same_len) begin
                res_valid_d = 1'b1;
              end else if (cmd_i.opcode == OP_CMP) begin
                rd_addr = LW'(ea + CW'(1));
                state_d = S_RH_HI;
              end else begin
                mm_go   = 1'b1;
                mm_b    = cmd_i.given_hash;
                state_d = S_GH_W;
              end
            end
            default: res_valid_d = 1'b1;
          endcase
        end
      end

      S_AP_RD: begin
        mm_go   = 1'b1;
        mm_b    = pow_rd;
        state_d = S_AP_PW;
      end
      S_AP_PW: begin
        if (!mm_run_q) begin
          mm_go   = 1'b1;
          mm_a    = mm_acc_q;
          mm_b    = base_q;
          state_d = S_AP_NP;
        end
      end
      S_AP_NP: begin
        if (!mm_run_q) begin
          mm_go   = 1'b1;
          mm_b    = HashW'(symdiff);
          state_d = S_AP_V;
        end
      end
      S_AP_V: begin
        if (!mm_run_q) begin
          mm_go   = 1'b1;
          mm_a    = vval;
          mm_b    = pw_q;
          state_d = S_AP_T;
        end
      end
      S_AP_T: begin
        if (!mm_run_q) begin
          mm_go   = 1'b1;
          mm_b    = preraw_q;
          state_d = S_AP_P;
        end
      end
      S_AP_P: begin
        if (!mm_run_q) begin
          wr_en       = 1'b1;
          len_d       = LW'(len_q + LW'(1));
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_RH_HI: begin
        mm_go   = 1'b1;
        state_d = S_RH_HIW;
      end
      S_RH_HIW: begin
        if (!mm_run_q) begin
          rd_addr = selb_q ? LW'(sb) : LW'(sa);
          state_d = S_RH_LO;
        end
      end
      S_RH_LO: begin
        mm_go   = 1'b1;
        state_d = S_RH_LOW;
      end
      S_RH_LOW: begin
        if (!mm_run_q) begin
          if (cmd_q.opcode == OP_HASH) begin
            res_d.hash_value = rh;
            res_valid_d      = 1'b1;
            state_d          = S_IDLE;
          end else if (!selb_q) begin
            selb_d  = 1'b1;
            rd_addr = LW'(eb + CW'(1));
            state_d = S_RH_HI;
          end else if (pos_gap == '0) begin
            res_d.ranges_equal = (ha_q == rh);
            res_valid_d        = 1'b1;
            state_d            = S_IDLE;
          end else begin
            rd_addr = LW'(pos_gap);
            state_d = S_AL_RD;
          end
        end
      end

      S_GH_W: begin
        if (!mm_run_q) begin
          selb_d  = 1'b1;
          rd_addr = LW'(eb + CW'(1));
          state_d = S_RH_HI;
        end
      end

      S_AL_RD: begin
        mm_go   = 1'b1;
        mm_a    = a_first ? ha_q : hb_q;
        mm_b    = pow_rd;
        state_d = S_AL_W;
      end
      S_AL_W: begin
        if (!mm_run_q) begin
          res_d.ranges_equal = a_first ? (mm_acc_q == hb_q) : (ha_q == mm_acc_q);
          res_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      selb_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      selb_q      <= selb_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Capture payload and intermediate values
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == S_IDLE && start_i) cmd_q <= cmd_i;
    if (state_q == S_AP_RD) preraw_q <= pre_rd;
    if (state_q == S_AP_PW && !mm_run_q) pw_q <= mm_acc_q;
    if (state_q == S_AP_NP && !mm_run_q) np_q <= mm_acc_q;
    if (state_q == S_AP_T && !mm_run_q) t_q <= mm_acc_q;
    if (state_q == S_RH_HIW && !mm_run_q) hi_q <= mm_acc_q;
    if (state_q == S_GH_W && !mm_run_q) ha_q <= mm_acc_q;
    if (state_q == S_RH_LOW && !mm_run_q) begin
      if (!selb_q) ha_q <= rh;
      else         hb_q <= rh;
    end
  end

endmodule

FILE: test/substring_poly_hash_compare_top_tb.sv
module substring_poly_hash_compare_top_tb
  import sphc_pkg::*;
();

  localparam int unsigned MaxLen = 1024;

  // Opcodes with no function
  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;

  // Track the string state, predict each result, and compare results in order
  class prefix_hash_predictor;
    bit [63:0] prefix_sums[MaxLen+1];
    bit [63:0] base_powers[MaxLen+1];
    int unsigned str_len;
    bit [63:0] base_reg, mod_reg;
    res_t expected_results[$];
    int unsigned mismatches, checked, equal_hits, errors_seen;

    function new();
      base_reg = BASE_RST;
      mod_reg = MOD_RST;
      prefix_sums[0] = 0;
      base_powers[0] = 1;
      str_len = 0;
    endfunction

    function bit [63:0] eff_mod();
      return (mod_reg < 3) ? 64'd3 : mod_reg;
    endfunction

    function void write_reg(logic idx, bit [30:0] data);
      if (idx == CFG_BASE) base_reg = data;
      else base_reg = base_reg;
      if (idx == CFG_MOD) mod_reg = data;
    endfunction

    function bit range_ok(int unsigned s, int unsigned e);
      return s <= e && e < str_len;
    endfunction

    function bit [63:0] range_hash(int unsigned s, int unsigned e);
      bit [63:0] m, hi, lo;
      m = eff_mod();
      hi = prefix_sums[e+1] % m;
      lo = prefix_sums[s] % m;
      return (hi + m - lo) % m;
    endfunction

    // Predict the result of one accepted command and queue it
    function void note_cmd(cmd_t c);
      res_t r;
      bit [63:0] m, v, pw, ha, hb;
      int unsigned n, sa, ea, sb, eb;
      m = eff_mod();
      r = '0;
      sa = c.start_a; ea = c.end_a; sb = c.start_b; eb = c.end_b;
      case (c.opcode) inside
        OP_CLEAR: begin
          str_len = 0;
          prefix_sums[0] = 0;
          base_powers[0] = 1;
        end
        OP_APPEND: begin
          n = str_len;
          if (n >= MaxLen) begin
            r.status = ST_FULL;
          end else begin
            if (c.symbol >= LETTER_OFS) v = (c.symbol - LETTER_OFS) % m;
            else v = (m - ((LETTER_OFS - c.symbol) % m)) % m;
            pw = base_powers[n] % m;
            prefix_sums[n+1] = (prefix_sums[n] % m + v * pw) % m;
            base_powers[n+1] = (pw * (base_reg % m)) % m;
            str_len = n + 1;
          end
        end
        OP_HASH: begin
          if (!range_ok(sa, ea)) r.status = ST_RANGE;
          else r.hash_value = HashW'(range_hash(sa, ea));
        end
        OP_CMP, OP_CMP_GIV: begin
          if (!range_ok(sa, ea) || !range_ok(sb, eb)) begin
            r.status = ST_RANGE;
          end else if (ea - sa == eb - sb) begin
            ha = (c.opcode == OP_CMP) ? range_hash(sa, ea) : c.given_hash % m;
            hb = range_hash(sb, eb);
            if (sa < sb) ha = (ha * (base_powers[sb-sa] % m)) % m;
            else if (sa > sb) hb = (hb * (base_powers[sa-sb] % m)) % m;
            r.ranges_equal = (ha == hb);
          end
        end
        default: ;
      endcase
      if (r.ranges_equal) equal_hits++;
      if (r.status != ST_OK) errors_seen++;
      expected_results.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t exp;
      checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result hash=%0d eq=%0d st=%0d",
                                       got.hash_value, got.ranges_equal, got.status);
        return;
      end
      exp = expected_results.pop_front();
      if (got.hash_value !== exp.hash_value || got.ranges_equal !== exp.ranges_equal ||
          got.status !== exp.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp hash=%0d eq=%0d st=%0d, got hash=%0d eq=%0d st=%0d",
                   exp.hash_value, exp.ranges_equal, exp.status,
                   got.hash_value, got.ranges_equal, got.status);
      end
    endfunction
  endclass

  logic             clk_i, rst_ni;
  logic             start_i, busy_o;
  cmd_t             cmd_i;
  logic             res_valid_o;
  res_t             res_o;
  logic             cfg_valid_i, cfg_ready_o;
  logic             cfg_index_i;
  logic [HashW-1:0] cfg_data_i;

  prefix_hash_predictor hash_pred;
  int unsigned n_sent;

  substring_poly_hash_compare_top #(.MAX_LENGTH(MaxLen)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .res_valid_o, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Check every strobed result
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) hash_pred.check_result(res_o);
  end

  // Hold start high until the block takes the command; keep it high on back-to-back
  task automatic issue_cmd(cmd_t c);
    int unsigned gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy_o);
    hash_pred.note_cmd(c);
    n_sent++;
  endtask

  // Drain outstanding results, then write both registers
  task automatic set_config(bit [30:0] base, bit [30:0] modulus);
    start_i <= 1'b0;
    do @(posedge clk_i); while (hash_pred.expected_results.size() != 0 || busy_o);
    for (int i = 0; i < 2; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= (i == 0) ? CFG_BASE : CFG_MOD;
      cfg_data_i <= (i == 0) ? base : modulus;
      do @(posedge clk_i); while (!cfg_ready_o);
      hash_pred.write_reg((i == 0) ? CFG_BASE : CFG_MOD, (i == 0) ? base : modulus);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic cmd_t noise_cmd();
    cmd_t c;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    c = raw[$bits(cmd_t)-1:0];
    return c;
  endfunction

  // Build a mostly well-formed command against the current string
  function automatic cmd_t gen_cmd(int unsigned append_pct);
    cmd_t c;
    int unsigned r, len, span;
    c = noise_cmd();
    len = hash_pred.str_len;
    r = $urandom_range(0, 99);
    if (r < append_pct) begin
      c.opcode = OP_APPEND;
      if ($urandom_range(0, 9) < 7) c.symbol = 8'($urandom_range(97, 98));
      return c;
    end
    if (r < append_pct + 2) begin
      c.opcode = OP_CLEAR;
      return c;
    end
    if (r > 93) return c;
    c.opcode = (r % 3 == 0) ? OP_HASH : (r % 3 == 1) ? OP_CMP : OP_CMP_GIV;
    if (len == 0 || $urandom_range(0, 9) == 0) return c;
    c.start_a = IdxW'($urandom_range(0, len - 1));
    c.end_a = IdxW'($urandom_range(c.start_a, len - 1));
    c.start_b = IdxW'($urandom_range(0, len - 1));
    c.end_b = IdxW'($urandom_range(c.start_b, len - 1));
    if ($urandom_range(0, 9) < 7) begin
      span = c.end_a - c.start_a;
      c.start_b = IdxW'($urandom_range(0, len - 1 - span));
      c.end_b = IdxW'(c.start_b + span);
    end
    if (c.opcode == OP_CMP_GIV && $urandom_range(0, 1)) begin
      c.given_hash = HashW'(hash_pred.range_hash(c.start_a, c.end_a));
      if ($urandom_range(0, 1) && c.given_hash + hash_pred.eff_mod() < 64'h8000_0000)
        c.given_hash = HashW'(c.given_hash + hash_pred.eff_mod());
    end
    return c;
  endfunction

  function automatic cmd_t mk(logic [2:0] op, int unsigned sym, int unsigned sa,
                              int unsigned ea, int unsigned sb, int unsigned eb,
                              bit [30:0] gh);
    cmd_t c;
    c.opcode = op; c.symbol = 8'(sym); c.start_a = IdxW'(sa); c.end_a = IdxW'(ea);
    c.start_b = IdxW'(sb); c.end_b = IdxW'(eb); c.given_hash = gh;
    return c;
  endfunction

  initial begin
    hash_pred = new();
    n_sent = 0;
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    cmd_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_BASE;
    cfg_data_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unused opcodes, errors on empty string, symbol extremes, compares
    issue_cmd(mk(OpSpareLo, 255, 1023, 1023, 1023, 1023, 31'h7FFF_FFFF));
    issue_cmd(mk(OpSpareHi, 0, 0, 0, 0, 0, 0));
    issue_cmd(mk(OP_HASH, 0, 0, 0, 0, 0, 0));
    issue_cmd(mk(OP_APPEND, 0, 0, 0, 0, 0, 0));
    issue_cmd(mk(OP_APPEND, 255, 0, 0, 0, 0, 0));
    issue_cmd(mk(OP_APPEND, 96, 0, 0, 0, 0, 0));
    issue_cmd(mk(OP_APPEND, 97, 0, 0, 0, 0, 0));
    issue_cmd(mk(OP_APPEND, 0, 0, 0, 0, 0, 0));
    issue_cmd(mk(OP_APPEND, 255, 0, 0, 0, 0, 0));
    issue_cmd(mk(OP_HASH, 0, 0, 5, 0, 0, 0));
    issue_cmd(mk(OP_HASH, 0, 3, 2, 0, 0, 0));
    issue_cmd(mk(OP_HASH, 0, 2, 6, 0, 0, 0));
    issue_cmd(mk(OP_CMP, 0, 0, 1, 4, 5, 0));
    issue_cmd(mk(OP_CMP, 0, 4, 5, 0, 1, 0));
    issue_cmd(mk(OP_CMP, 0, 0, 2, 3, 4, 0));
    issue_cmd(mk(OP_CMP, 0, 0, 1, 4, 6, 0));
    issue_cmd(mk(OP_CMP_GIV, 0, 0, 1, 4, 5, 31'h7FFF_FFFF));
    issue_cmd(mk(OP_CMP_GIV, 0, 1, 1, 1, 1, HashW'(hash_pred.range_hash(1, 1))));
    issue_cmd(mk(OP_CMP_GIV, 0, 0, 0, 3, 2, 0));
    issue_cmd(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    issue_cmd(mk(OP_HASH, 0, 0, 0, 0, 0, 0));

    // Random phases across register settings; the string carries over each change
    set_config(31'd53, 31'd1000000007);
    repeat (40) issue_cmd(gen_cmd(40));
    set_config(31'd2, 31'd3);
    repeat (40) issue_cmd(gen_cmd(35));
    set_config(31'd2147483646, 31'd2147483647);
    repeat (40) issue_cmd(gen_cmd(30));
    set_config(31'h7FFF_FFFF, 31'd1000);
    repeat (40) issue_cmd(gen_cmd(30));
    set_config(31'd7, 31'd1);
    repeat (40) issue_cmd(gen_cmd(30));
    set_config(31'd0, 31'd0);
    repeat (20) issue_cmd(gen_cmd(30));

    // Fill the store, overflow it, then query long ranges
    set_config(31'd131, 31'd1000000007);
    issue_cmd(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    while (hash_pred.str_len < MaxLen) issue_cmd(gen_cmd(100));
    repeat (3) issue_cmd(mk(OP_APPEND, $urandom, 0, 0, 0, 0, 0));
    issue_cmd(mk(OP_HASH, 0, 0, 1023, 0, 0, 0));
    issue_cmd(mk(OP_CMP, 0, 0, 511, 512, 1023, 0));
    issue_cmd(mk(OP_CMP, 0, 1023, 1023, 0, 0, 0));
    issue_cmd(mk(OP_CMP_GIV, 0, 0, 1022, 1, 1023, 0));
    repeat (30) issue_cmd(gen_cmd(0));

    // Drain and report
    start_i <= 1'b0;
    do @(posedge clk_i); while (hash_pred.expected_results.size() != 0);
    repeat (200) @(posedge clk_i);
    $display("commands sent %0d, results checked %0d, equal compares %0d, error results %0d",
             n_sent, hash_pred.checked, hash_pred.equal_hits, hash_pred.errors_seen);
    $display("mismatches %0d", hash_pred.mismatches);
    if (hash_pred.mismatches == 0 && hash_pred.expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(36_000_000);
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
src/sphc_pkg.sv
src/substring_poly_hash_compare_top.sv
test/substring_poly_hash_compare_top_tb.sv
